[rtl/core/gamepad_frame_builder_crc16_assert.svh]
// Assertion macros shared by the gamepad frame builder RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef GAMEPAD_FRAME_BUILDER_CRC16_ASSERT_SVH
`define GAMEPAD_FRAME_BUILDER_CRC16_ASSERT_SVH

// Checked at every clock edge outside of reset.
`define GFB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define GFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/gfb_pkg.sv]
// Package for the gamepad frame builder: payload types, frame constants
// and the CRC-16 and dead-zone helper functions. Depends on nothing.
package gfb_pkg;

  localparam int unsigned FrameLen = 13;
  localparam int unsigned DataLen  = 10;
  localparam int unsigned PosW     = $clog2(FrameLen);
  localparam int unsigned AddrW    = 3;

  localparam logic [7:0]  FrameHeader   = 8'h0A;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'h1021;
  localparam logic [15:0] CrcTop        = 16'h8000;
  localparam logic [15:0] DeadZoneReset = 16'd7849;

  localparam logic RegDeadZone = 1'b0;

  typedef struct packed {
    logic [13:0]        button_bits;
    logic signed [15:0] left_stick_x;
    logic signed [15:0] left_stick_y;
    logic signed [15:0] right_stick_x;
    logic signed [15:0] right_stick_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
  } gfb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } gfb_out_t;

  typedef logic [DataLen-1:0][7:0]  gfb_data_t;
  typedef logic [FrameLen-1:0][7:0] gfb_frame_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = ((c & CrcTop) != 16'h0000) ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] dead_zone_apply(input logic [15:0] v, input logic [15:0] dz);
    logic [16:0] mag;
    mag = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    return (mag < {1'b0, dz}) ? 16'h0000 : v;
  endfunction

endpackage

[rtl/core/gfb_crc_pipe.sv]
// CRC-16 pipeline of the gamepad frame builder, one frame byte per stage.
// Depends on gfb_pkg and the assertion macro header.
`include "gamepad_frame_builder_crc16_assert.svh"

module gfb_crc_pipe import gfb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  gfb_data_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output gfb_data_t   out_data_o,
  output logic [15:0] out_crc_o
);

  logic      vld  [DataLen+1];
  logic      rdy  [DataLen+1];
  gfb_data_t data [DataLen+1];
  logic [15:0] crc [DataLen+1];

  assign vld[0]       = in_valid_i;
  assign data[0]      = in_data_i;
  assign crc[0]       = CrcInit;
  assign rdy[DataLen] = out_ready_i;

  for (genvar j = 0; j < DataLen; j++) begin : g_stage
    logic        vld_q;
    gfb_data_t   data_q;
    logic [15:0] crc_q;

    assign rdy[j]     = !vld_q || rdy[j+1];
    assign vld[j+1]   = vld_q;
    assign data[j+1]  = data_q;
    assign crc[j+1]   = crc_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (rdy[j]) begin
        vld_q <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j] && vld[j]) begin
        data_q <= data[j];
        crc_q  <= crc_byte(crc[j], data[j][j]);
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld[DataLen];
  assign out_data_o  = data[DataLen];
  assign out_crc_o   = crc[DataLen];

  `GFB_ASSERT(a_stall_holds, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_crc_o)), "CRC pipe lost a stalled word")
  `GFB_ASSERT(a_ready_when_free, clk_i, rst_ni, !out_valid_o |-> rdy[DataLen-1], "last CRC stage blocked while empty")
  `GFB_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "CRC pipe valid during reset")

endmodule

[rtl/core/gfb_frame_tx.sv]
// Frame sender of the gamepad frame builder: holds one 13-byte frame and
// sends it one byte per word. Depends on gfb_pkg and the assertion macro header.
`include "gamepad_frame_builder_crc16_assert.svh"

module gfb_frame_tx import gfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       frame_valid_i,
  output logic       frame_ready_o,
  input  gfb_frame_t frame_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output gfb_out_t   out_data_o
);

  gfb_frame_t      frame_q;
  logic            busy_q, busy_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            last;
  logic            send;
  logic            load;

  assign last          = (pos_q == PosW'(FrameLen - 1));
  assign send          = busy_q && out_ready_i;
  assign frame_ready_o = !busy_q || (out_ready_i && last);
  assign load          = frame_valid_i && frame_ready_o;

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (send) begin
      pos_d  = last ? '0 : pos_q + PosW'(1);
      busy_d = !last;
    end
    if (load) begin
      busy_d = 1'b1;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_i;
    end
  end

  assign out_valid_o           = busy_q;
  assign out_data_o.frame_byte = frame_q[pos_q];
  assign out_data_o.frame_end  = last;

  `GFB_ASSERT(a_pos_range, clk_i, rst_ni, busy_q |-> (pos_q < PosW'(FrameLen)), "byte position past frame end")
  `GFB_ASSERT(a_pos_wrap, clk_i, rst_ni, (send && last) |=> (pos_q == '0), "byte position did not wrap after last byte")
  `GFB_ASSERT(a_pos_step, clk_i, rst_ni, (send && !last) |=> (busy_q && (pos_q == $past(pos_q) + PosW'(1))), "byte position skipped or repeated")

endmodule

[rtl/core/gamepad_frame_builder_crc16.sv]
// Top level of the gamepad frame builder with CRC-16 framing.
// Depends on gfb_pkg, gfb_crc_pipe and gfb_frame_tx.
//
//   Channel   Signals                                  Width  Direction
//   in        in_valid_i, in_ready_o, in_data_i        94     snapshot in
//   out       out_valid_o, out_ready_i, out_data_o     9      frame byte out
//   cfg       psel, penable, pwrite, paddr, pwdata,    32     register access
//             prdata, pready
//
// A snapshot passes an input register, a dead-zone and packing stage, ten CRC
// stages of one byte each and the frame register, in that order. Each frame leaves
// through the one-byte output port a byte at a time, and the next frame is loaded
// when the last byte of the one before is taken; up to 12 more snapshots wait in
// the pipeline. Reset clears all valid bits and loads the dead zone with 7849;
// a stall on the output holds every stage without loss.
module gamepad_frame_builder_crc16 import gfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gfb_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gfb_out_t         out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] dz_q;
  logic        in_vld_q;
  gfb_in_t     in_q;
  logic        asm_vld_q;
  gfb_data_t   asm_q;
  gfb_data_t   asm_d;
  logic        asm_rdy;
  logic        crc_in_ready;
  logic        crc_valid;
  logic        crc_ready;
  gfb_data_t   crc_data;
  logic [15:0] crc_val;
  gfb_frame_t  frame;
  logic [15:0] lx, ly, rx, ry;

  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1] == RegDeadZone) ? {16'h0000, dz_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= DeadZoneReset;
    end else if (psel && penable && pwrite && pready && (paddr[AddrW-1] == RegDeadZone)) begin
      dz_q <= pwdata[15:0];
    end
  end

  assign in_ready_o = !in_vld_q || asm_rdy;
  assign asm_rdy    = !asm_vld_q || crc_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      asm_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (asm_rdy) begin
        asm_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (in_vld_q && asm_rdy) begin
      asm_q <= asm_d;
    end
  end

  always_comb begin
    lx       = dead_zone_apply(in_q.left_stick_x, dz_q);
    ly       = dead_zone_apply(in_q.left_stick_y, dz_q);
    rx       = dead_zone_apply(in_q.right_stick_x, dz_q);
    ry       = dead_zone_apply(in_q.right_stick_y, dz_q);
    asm_d[0] = in_q.button_bits[13:6];
    asm_d[1] = lx[15:8];
    asm_d[2] = lx[7:0];
    asm_d[3] = ly[15:8];
    asm_d[4] = ly[7:0];
    asm_d[5] = rx[15:8];
    asm_d[6] = rx[7:0];
    asm_d[7] = ry[15:8];
    asm_d[8] = ry[7:0];
    asm_d[9] = {in_q.button_bits[5:2], (in_q.left_trigger != 8'h00),
                (in_q.right_trigger != 8'h00), in_q.button_bits[1:0]};
  end

  gfb_crc_pipe u_crc_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (asm_vld_q),
    .in_ready_o  (crc_in_ready),
    .in_data_i   (asm_q),
    .out_valid_o (crc_valid),
    .out_ready_i (crc_ready),
    .out_data_o  (crc_data),
    .out_crc_o   (crc_val)
  );

  always_comb begin
    frame[0] = FrameHeader;
    for (int i = 0; i < DataLen; i++) begin
      frame[i+1] = crc_data[i];
    end
    frame[FrameLen-2] = crc_val[15:8];
    frame[FrameLen-1] = crc_val[7:0];
  end

  gfb_frame_tx u_frame_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (crc_valid),
    .frame_ready_o (crc_ready),
    .frame_i       (frame),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule
